@@ sv/dhc_pkg.sv @@
package dhc_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_ACCUM = 2'd0,
		FUNC_FINAL = 2'd1,
		FUNC_MAP   = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	localparam int CNT_W     = 20;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int IDX_W     = 11;
	localparam logic [IDX_W-1:0] IDX_TOP = 11'd1275;
	localparam int PROD_W    = CNT_W + IDX_W;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CLR   = 11'b00000000010,
		ST_ACC_R = 11'b00000000100,
		ST_ACC_W = 11'b00000001000,
		ST_FIN_R = 11'b00000010000,
		ST_FIN_W = 11'b00000100000,
		ST_MAP_A = 11'b00001000000,
		ST_MAP_B = 11'b00010000000,
		ST_MUL   = 11'b00100000000,
		ST_DIV   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} state_t;

	// rainbow lookup for a saturated index
	function automatic logic [23:0] rainbow(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] i;
		logic [7:0] r, g, b;
		i = (idx > IDX_TOP) ? IDX_TOP : idx;
		if (i <= 11'd255) begin
			r = 8'd255; g = i[7:0]; b = 8'd0;
		end else if (i <= 11'd510) begin
			r = 8'(11'd510 - i); g = 8'd255; b = 8'd0;
		end else if (i <= 11'd765) begin
			r = 8'd0; g = 8'd255; b = 8'(i - 11'd510);
		end else if (i <= 11'd1020) begin
			r = 8'd0; g = 8'(11'd1020 - i); b = 8'd255;
		end else begin
			r = 8'(i - 11'd1020); g = 8'd0; b = 8'd255;
		end
		return {r, g, b};
	endfunction

endpackage

@@ sv/depth_histogram_colormap.sv @@
// Histogram-equalised depth colouring.
// Input channel (valid/ready): func, depth. func 0 counts a depth into the
// histogram, 1 turns it into a running sum up to the largest depth seen,
// 2 maps a depth to a colour, 3 clears. Only map items give an output beat
// (has_color, red, green, blue) on the valid/ready output channel.
// One item at a time; ready is low while an item is in work.
// Accumulate: memory read, then write back. Map: pixel bin read, largest
// bin read, multiply, restoring divide, output beat; a map of depth 0 gives
// its beat in the next cycle. The output then waits for out_ready.
// Finalize: a read and a write per bin up to the largest depth (shared memory port).
// Clear: one bin a cycle, over all DEPTH_BINS bins.
// After reset a clearing pass sweeps all DEPTH_BINS bins of the histogram
// memory; no item is accepted meanwhile.
// A stalled output beat holds; the next item is taken only once the beat
// has gone.
module depth_histogram_colormap
	import dhc_pkg::*;
#(
	parameter int DEPTH_BINS       = 16384,
	parameter int MAX_FRAME_PIXELS = 524288
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  func,
	input  logic [15:0] depth,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        has_color,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	localparam int AW = (DEPTH_BINS > 1) ? $clog2(DEPTH_BINS) : 1;
	localparam int FRAME_W = $clog2(MAX_FRAME_PIXELS + 1);
	localparam logic [16:0] BINS = 17'(DEPTH_BINS);

	// histogram memory
	logic [CNT_W-1:0] mem [DEPTH_BINS];
	logic [CNT_W-1:0] rd_q;
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [CNT_W-1:0] wdata;

	state_t           st_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    largest_q;
	logic [CNT_W-1:0] prev_q, num_q, den_q;
	logic [PROD_W-1:0] prod_q, rem_q;
	logic [IDX_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             black_q;
	logic [FRAME_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign ready = (st_q == ST_IDLE) && !out_valid;

	logic [CNT_W:0] sum;
	assign sum = {1'b0, rd_q} + {1'b0, prev_q};

	logic [PROD_W:0] trial;
	assign trial = {rem_q[PROD_W-1:0], prod_q[PROD_W-1]} - {{(IDX_W+1){1'b0}}, den_q};

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = '0;
		raddr = ptr_q;
		unique case (st_q)
			ST_CLR: we = 1'b1;
			ST_ACC_W: begin
				we = 1'b1;
				wdata = (rd_q == CNT_MAX) ? CNT_MAX : rd_q + 1'b1;
			end
			ST_FIN_W: begin
				we = 1'b1;
				wdata = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
			end
			ST_MAP_B: raddr = largest_q;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLR;
			ptr_q     <= '0;
			largest_q <= '0;
			out_valid <= 1'b0;
			pix_q     <= '0;
			prev_q    <= '0;
			num_q     <= '0;
			den_q     <= '0;
			prod_q    <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			cnt_q     <= '0;
			black_q   <= 1'b0;
			has_color <= 1'b0;
			{red, green, blue} <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (valid && ready) begin
					unique case (func_t'(func))
						FUNC_ACCUM: if (depth != 16'd0 && {1'b0, depth} < BINS) begin
							ptr_q <= depth[AW-1:0];
							st_q  <= ST_ACC_R;
						end
						FUNC_FINAL: begin
							prev_q <= '0;
							ptr_q  <= '0;
							if (largest_q != '0) st_q <= ST_FIN_R;
						end
						FUNC_MAP: if (depth == 16'd0) begin
							has_color <= 1'b0;
							{red, green, blue} <= '0;
							out_valid <= 1'b1;
						end else begin
							black_q <= {1'b0, depth} >= BINS ||
								depth[AW-1:0] > largest_q;
							ptr_q <= depth[AW-1:0];
							st_q  <= ST_MAP_A;
						end
						FUNC_CLEAR: begin
							ptr_q     <= '0;
							largest_q <= '0;
							pix_q     <= '0;
							st_q      <= ST_CLR;
						end
						default: ;
					endcase
				end
				ST_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == AW'(DEPTH_BINS - 1)) st_q <= ST_IDLE;
				end
				ST_ACC_R: st_q <= ST_ACC_W;
				ST_ACC_W: begin
					if (ptr_q > largest_q) largest_q <= ptr_q;
					if (pix_q != FRAME_W'(MAX_FRAME_PIXELS)) pix_q <= pix_q + 1'b1;
					st_q <= ST_IDLE;
				end
				ST_FIN_R: st_q <= ST_FIN_W;
				ST_FIN_W: begin
					prev_q <= wdata;
					ptr_q  <= ptr_q + 1'b1;
					st_q   <= (ptr_q == largest_q) ? ST_IDLE : ST_FIN_R;
				end
				// bin of the pixel being read
				ST_MAP_A: st_q <= ST_MAP_B;
				// pixel bin arrives, bin of the largest depth being read
				ST_MAP_B: begin
					num_q <= rd_q;
					st_q  <= ST_MUL;
				end
				ST_MUL: begin
					den_q  <= rd_q;
					prod_q <= PROD_W'(num_q) * PROD_W'(IDX_TOP);
					rem_q  <= '0;
					quo_q  <= '0;
					cnt_q  <= 5'(PROD_W - 1);
					st_q   <= ST_DIV;
				end
				// restoring divide, one quotient bit a cycle, saturating
				ST_DIV: begin
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
					if (!trial[PROD_W]) begin
						rem_q <= trial[PROD_W-1:0];
						quo_q <= (quo_q > (IDX_TOP >> 1)) ? IDX_TOP : {quo_q[IDX_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[PROD_W-2:0], prod_q[PROD_W-1]};
						quo_q <= (quo_q > (IDX_TOP >> 1)) ? IDX_TOP : {quo_q[IDX_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 5'd0) st_q <= ST_OUT;
				end
				ST_OUT: begin
					has_color <= 1'b1;
					if (black_q) {red, green, blue} <= '0;
					else if (den_q == '0) {red, green, blue} <= rainbow('0);
					else {red, green, blue} <= rainbow(quo_q);
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
